// ----- hw/rtl/rpu_pkg.sv -----
// Shared types, codes and constants of the raw pixel unpacker.
`timescale 1ns / 1ps
package rpu_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int DIM_W       = 13;
	localparam int COORD_W     = 12;
	localparam int REG_IDX_W   = 2;
	localparam int FMT_W       = 3;

	// Pixel formats.
	localparam logic [FMT_W-1:0] FMT_RGBA32 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_RGB24  = 3'd1;
	localparam logic [FMT_W-1:0] FMT_IDX8   = 3'd2;
	localparam logic [FMT_W-1:0] FMT_IDX4   = 3'd3;
	localparam logic [FMT_W-1:0] FMT_IDX1   = 3'd4;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_FORMAT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA  = 2'd3;

	// How a held item is split into pixels.
	localparam logic [1:0] MODE_RGBA = 2'd0;
	localparam logic [1:0] MODE_IDX8 = 2'd1;
	localparam logic [1:0] MODE_IDX4 = 2'd2;
	localparam logic [1:0] MODE_IDX1 = 2'd3;

	typedef struct packed {
		logic [FMT_W-1:0] fmt;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [7:0]       alpha;
		logic             restart;
	} cfg_t;

	typedef struct packed {
		logic       is_indexed;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_run;
	} pix_t;

endpackage

// ----- hw/rtl/rpu_byte_if.sv -----
// Handshake channel that carries one raw byte per transfer.
`timescale 1ns / 1ps
interface rpu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;

	modport source (output valid, output raw_byte, input ready);
	modport sink (input valid, input raw_byte, output ready);
endinterface

// ----- hw/rtl/rpu_pixel_if.sv -----
// Handshake channel that carries one unpacked pixel per transfer.
`timescale 1ns / 1ps
interface rpu_pixel_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic        is_indexed;
	logic [7:0]  chan_red;
	logic [7:0]  chan_green;
	logic [7:0]  chan_blue;
	logic [7:0]  chan_alpha;
	logic        last_of_run;
	logic        last_of_image;

	modport source (output valid, output pixel_x, output pixel_y, output is_indexed,
		output chan_red, output chan_green, output chan_blue, output chan_alpha,
		output last_of_run, output last_of_image, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input is_indexed,
		input chan_red, input chan_green, input chan_blue, input chan_alpha,
		input last_of_run, input last_of_image, output ready);
endinterface

// ----- hw/rtl/rpu_cfg.sv -----
// Configuration registers with dimension clamping and restart pulse.
`timescale 1ns / 1ps
module rpu_cfg #(
	parameter int MAX_DIM = rpu_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rpu_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [rpu_pkg::DIM_W-1:0]      wr_data,
	output rpu_pkg::cfg_t                  cfg
);
	import rpu_pkg::*;

	logic [FMT_W-1:0] fmt_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [7:0]       alpha_q;
	logic             restart;

	// Zero reads as one row or column; anything above the limit reads as the limit.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RGBA32;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			alpha_q  <= 8'hff;
		end else if (wr_en) begin
			case (wr_index)
				REG_FORMAT: fmt_q    <= wr_data[FMT_W-1:0];
				REG_WIDTH:  width_q  <= clamp_dim(wr_data);
				REG_HEIGHT: height_q <= clamp_dim(wr_data);
				REG_ALPHA:  alpha_q  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_index)
			REG_FORMAT, REG_WIDTH, REG_HEIGHT, REG_ALPHA: restart = wr_en;
			default: restart = 1'b0;
		endcase
	end

	assign cfg.fmt     = fmt_q;
	assign cfg.width   = width_q;
	assign cfg.height  = height_q;
	assign cfg.alpha   = alpha_q;
	assign cfg.restart = restart;

endmodule

// ----- hw/rtl/rpu_gather.sv -----
// Byte intake: gathers color bytes and splits held items into single pixels.
`timescale 1ns / 1ps
module rpu_gather (
	input  logic          clk,
	input  logic          arst_n,
	input  rpu_pkg::cfg_t cfg,
	rpu_byte_if.sink      raw,
	output logic          pix_valid,
	output rpu_pkg::pix_t pix,
	input  logic          pix_ready
);
	import rpu_pkg::*;

	logic        s1_valid;
	logic [1:0]  mode_s1;
	logic [31:0] word_s1;
	logic [2:0]  idx_s1;
	logic [1:0]  phase_q;
	logic [23:0] held_q;

	logic        take;
	logic        done;
	logic        acc;
	logic        load;
	logic [1:0]  load_mode;
	logic [31:0] load_word;
	logic [7:0]  b;

	assign b = word_s1[7:0];

	always_comb begin
		pix = '0;
		pix.is_indexed = 1'b1;
		case (mode_s1)
			MODE_RGBA: begin
				pix.is_indexed  = 1'b0;
				pix.red         = word_s1[7:0];
				pix.green       = word_s1[15:8];
				pix.blue        = word_s1[23:16];
				pix.alpha       = word_s1[31:24];
				pix.last_of_run = 1'b1;
			end
			MODE_IDX8: begin
				pix.red         = b;
				pix.last_of_run = 1'b1;
			end
			MODE_IDX4: begin
				pix.red         = idx_s1[0] ? {4'b0, b[3:0]} : {4'b0, b[7:4]};
				pix.last_of_run = idx_s1[0];
			end
			MODE_IDX1: begin
				pix.red         = {7'b0, b[3'd7 - idx_s1]};
				pix.last_of_run = (idx_s1 == 3'd7);
			end
			default: ;
		endcase
	end

	assign pix_valid = s1_valid;
	assign take      = s1_valid && pix_ready;
	assign done      = take && pix.last_of_run;
	assign raw.ready = !s1_valid || done;
	assign acc       = raw.valid && raw.ready;

	// Decide whether the accepted byte completes an item for the split stage.
	always_comb begin
		load      = 1'b0;
		load_mode = MODE_IDX8;
		load_word = {24'b0, raw.raw_byte};
		case (cfg.fmt)
			FMT_RGBA32: begin
				load      = (phase_q == 2'd3);
				load_mode = MODE_RGBA;
				load_word = {raw.raw_byte, held_q};
			end
			FMT_RGB24: begin
				load      = (phase_q == 2'd2);
				load_mode = MODE_RGBA;
				load_word = {cfg.alpha, raw.raw_byte, held_q[15:0]};
			end
			FMT_IDX8: begin
				load      = 1'b1;
				load_mode = MODE_IDX8;
			end
			FMT_IDX4: begin
				load      = 1'b1;
				load_mode = MODE_IDX4;
			end
			FMT_IDX1: begin
				load      = 1'b1;
				load_mode = MODE_IDX1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			idx_s1   <= '0;
			phase_q  <= '0;
		end else begin
			if (acc && load) begin
				s1_valid <= 1'b1;
				idx_s1   <= '0;
			end else if (done) begin
				s1_valid <= 1'b0;
			end else if (take) begin
				idx_s1 <= idx_s1 + 3'd1;
			end

			if (cfg.restart) begin
				phase_q <= '0;
			end else if (acc && (cfg.fmt == FMT_RGBA32 || cfg.fmt == FMT_RGB24)) begin
				phase_q <= load ? 2'd0 : phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && load) begin
			mode_s1 <= load_mode;
			word_s1 <= load_word;
		end
		if (acc && !load && (cfg.fmt == FMT_RGBA32 || cfg.fmt == FMT_RGB24)) begin
			held_q[8*phase_q +: 8] <= raw.raw_byte;
		end
	end

endmodule

// ----- hw/rtl/rpu_emit.sv -----
// Raster position counters and the output register of the pixel channel.
`timescale 1ns / 1ps
module rpu_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  rpu_pkg::cfg_t cfg,
	input  logic          pix_valid,
	input  rpu_pkg::pix_t pix,
	output logic          pix_ready,
	rpu_pixel_if.source   pixel
);
	import rpu_pkg::*;

	logic             out_valid_q;
	pix_t             out_pix_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic             end_img_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic             take;
	logic             end_row;
	logic             end_img;

	assign pix_ready = !out_valid_q || pixel.ready;
	assign take      = pix_valid && pix_ready;
	assign end_row   = (col_q + DIM_W'(1)) >= cfg.width;
	assign end_img   = end_row && ((row_q + DIM_W'(1)) >= cfg.height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pixel.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (take) begin
				if (end_row) begin
					col_q <= '0;
					row_q <= end_img ? '0 : row_q + DIM_W'(1);
				end else begin
					col_q <= col_q + DIM_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_pix_q <= pix;
			x_q       <= col_q[COORD_W-1:0];
			y_q       <= row_q[COORD_W-1:0];
			end_img_q <= end_img;
		end
	end

	assign pixel.valid         = out_valid_q;
	assign pixel.pixel_x       = x_q;
	assign pixel.pixel_y       = y_q;
	assign pixel.is_indexed    = out_pix_q.is_indexed;
	assign pixel.chan_red      = out_pix_q.red;
	assign pixel.chan_green    = out_pix_q.green;
	assign pixel.chan_blue     = out_pix_q.blue;
	assign pixel.chan_alpha    = out_pix_q.alpha;
	assign pixel.last_of_run   = out_pix_q.last_of_run;
	assign pixel.last_of_image = end_img_q;

endmodule

// ----- hw/rtl/raw_pixel_unpacker_core.sv -----
// Top level of the raw pixel unpacker: byte channel in, pixel channel out.
// Path: a byte that completes a pixel passes the split stage register, then the output register.
// Throughput: up to one pixel per cycle while the receiver is ready, set by the single split stage
// feeding the output register; a 4 or 1 bpp byte is held until its last pixel has left.
// Reset (arst_n low, asynchronous) empties both stages, zeroes the raster position and byte
// phase, and loads format 32 bpp, width 1, height 1 and alpha 255.
`timescale 1ns / 1ps
module raw_pixel_unpacker_core #(
	parameter int MAX_DIM = rpu_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rpu_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [rpu_pkg::DIM_W-1:0]     wr_data,
	rpu_byte_if.sink                      raw,
	rpu_pixel_if.source                   pixel
);
	import rpu_pkg::*;

	// Configuration as seen by both stages. Any register write also restarts the
	// image: the raster position and the byte phase of 32/24 bpp return to zero.
	cfg_t cfg;

	// One pixel waiting in the split stage, handed on when the output register frees.
	logic pix_valid;
	logic pix_ready;
	pix_t pix;

	rpu_cfg #(
		.MAX_DIM(MAX_DIM)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// The intake gathers 32 and 24 bpp bytes into one color word and holds indexed
	// bytes while their pixels are split off one per transfer, high bits first.
	// A new byte is taken in the cycle that the last pixel of the held one leaves.
	rpu_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.raw       (raw),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_ready (pix_ready)
	);

	// The output stage tags each pixel with its column and row, wraps at the row
	// width and returns to the origin after the last pixel of the image.
	rpu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_ready (pix_ready),
		.pixel     (pixel)
	);

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of the raw pixel unpacker core.
`timescale 1ns / 1ps
module tb_top;
	import rpu_pkg::*;

	// One unpacked pixel: raster position, color or palette index, and the end flags.
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic        indexed;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        run_end;
		logic        image_end;
	} unpacked_pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [DIM_W-1:0]     wr_data;

	rpu_byte_if  raw_ch ();
	rpu_pixel_if pix_ch ();

	raw_pixel_unpacker_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.raw      (raw_ch.sink),
		.pixel    (pix_ch.source)
	);

	always #5 clk = ~clk;

	// Bytes waiting for the byte driver, and pixels the monitor still has to see.
	logic [7:0]      raw_backlog [$];
	unpacked_pixel_t pixels_due [$];
	int              bytes_queued = 0;
	int              bytes_taken = 0;
	int              mismatches = 0;

	// Percentages of cycles in which each side idles; the stimulus process changes them.
	int send_idle_pct = 20;
	int recv_idle_pct = 60;

	// One long receiver hold-off, requested by the stimulus and timed by the ready process.
	logic hold_request = 1'b0;
	logic hold_taken;
	int   hold_left;

	// Our own copy of the block's registers and raster state.
	logic [FMT_W-1:0] fmt_reg;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [7:0]       alpha_reg;
	logic [11:0]      col_pos;
	logic [11:0]      row_pos;
	logic [1:0]       gather_phase;
	logic [23:0]      gathered;

	// A width or height of zero acts as one; anything above the maximum acts as the maximum.
	function automatic int dim_limit(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(v);
	endfunction

	// Queues one pixel at the current raster position and steps the position on,
	// wrapping at the row width and returning to the origin after the last row.
	function automatic void emit_pixel(input logic ind, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a, input logic run_end);
		unpacked_pixel_t p;
		int   w;
		int   h;
		logic row_end;
		logic img_end;
		w = dim_limit(width_reg);
		h = dim_limit(height_reg);
		row_end = (int'(col_pos) + 1 >= w);
		img_end = row_end && (int'(row_pos) + 1 >= h);
		p = '{x: col_pos, y: row_pos, indexed: ind, red: r, green: g, blue: b, alpha: a,
			run_end: run_end, image_end: img_end};
		pixels_due.push_back(p);
		if (row_end) begin
			col_pos = '0;
			row_pos = img_end ? 12'd0 : row_pos + 12'd1;
		end else begin
			col_pos = col_pos + 12'd1;
		end
	endfunction

	// Works out every pixel that one accepted byte causes in the current format.
	function automatic void unpack_byte(input logic [7:0] b);
		case (fmt_reg)
			FMT_RGBA32: begin
				if (gather_phase < 2'd3) begin
					gathered[8*gather_phase +: 8] = b;
					gather_phase = gather_phase + 2'd1;
				end else begin
					gather_phase = 2'd0;
					emit_pixel(1'b0, gathered[7:0], gathered[15:8], gathered[23:16], b, 1'b1);
				end
			end
			FMT_RGB24: begin
				if (gather_phase < 2'd2) begin
					gathered[8*gather_phase +: 8] = b;
					gather_phase = gather_phase + 2'd1;
				end else begin
					gather_phase = 2'd0;
					emit_pixel(1'b0, gathered[7:0], gathered[15:8], b, alpha_reg, 1'b1);
				end
			end
			FMT_IDX8: emit_pixel(1'b1, b, 8'd0, 8'd0, 8'd0, 1'b1);
			FMT_IDX4: begin
				emit_pixel(1'b1, {4'd0, b[7:4]}, 8'd0, 8'd0, 8'd0, 1'b0);
				emit_pixel(1'b1, {4'd0, b[3:0]}, 8'd0, 8'd0, 8'd0, 1'b1);
			end
			FMT_IDX1: begin
				for (int i = 0; i < 8; i++)
					emit_pixel(1'b1, {7'd0, b[7-i]}, 8'd0, 8'd0, 8'd0, i == 7);
			end
			default: ;  // Undefined formats swallow the byte and change nothing.
		endcase
	endfunction

	// Byte driver: records each transfer in the predictor, then offers the next byte
	// from the backlog unless it decides to idle. Idle cycles carry random data.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_ch.valid    <= 1'b0;
			raw_ch.raw_byte <= 8'd0;
		end else begin
			if (raw_ch.valid && raw_ch.ready) begin
				unpack_byte(raw_ch.raw_byte);
				bytes_taken++;
			end
			if (!raw_ch.valid || raw_ch.ready) begin
				if (raw_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					raw_ch.valid    <= 1'b1;
					raw_ch.raw_byte <= raw_backlog.pop_front();
				end else begin
					raw_ch.valid    <= 1'b0;
					raw_ch.raw_byte <= 8'($urandom);
				end
			end
		end
	end

	// Pixel ready: random back-pressure, except for the one long hold-off, which
	// lets the block fill up while the byte driver keeps offering.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
			hold_taken   <= 1'b0;
			hold_left    <= 0;
		end else if (hold_request && !hold_taken) begin
			pix_ch.ready <= 1'b0;
			hold_taken   <= 1'b1;
			hold_left    <= 300;
		end else if (hold_left != 0) begin
			pix_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input logic [11:0] want,
			input logic [11:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 50)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Pixel monitor: every transfer is compared with the oldest pixel still due.
	always @(posedge clk) begin : pixel_monitor
		unpacked_pixel_t seen;
		unpacked_pixel_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			seen = '{x: pix_ch.pixel_x, y: pix_ch.pixel_y, indexed: pix_ch.is_indexed,
				red: pix_ch.chan_red, green: pix_ch.chan_green, blue: pix_ch.chan_blue,
				alpha: pix_ch.chan_alpha, run_end: pix_ch.last_of_run,
				image_end: pix_ch.last_of_image};
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 50)
					$display("%0t ns: pixel with none due, expected nothing, actual %p",
						$time, seen);
			end else begin
				want = pixels_due.pop_front();
				check_field("pixel_x", want.x, seen.x);
				check_field("pixel_y", want.y, seen.y);
				check_field("is_indexed", 12'(want.indexed), 12'(seen.indexed));
				check_field("chan_red", 12'(want.red), 12'(seen.red));
				check_field("chan_green", 12'(want.green), 12'(seen.green));
				check_field("chan_blue", 12'(want.blue), 12'(seen.blue));
				check_field("chan_alpha", 12'(want.alpha), 12'(seen.alpha));
				check_field("last_of_run", 12'(want.run_end), 12'(seen.run_end));
				check_field("last_of_image", 12'(want.image_end), 12'(seen.image_end));
			end
		end
	end

	function automatic void offer(input logic [7:0] b);
		raw_backlog.push_back(b);
		bytes_queued++;
	endfunction

	// Waits until every queued byte has been taken and every due pixel has come out.
	// Bytes that only fill a partial pixel count as taken without any output; the settling cycles follow.
	task automatic wait_idle(input int settle);
		while (bytes_taken != bytes_queued || pixels_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Writes all four registers back to back while the block is idle. Each write
	// restarts the image, so the predictor's raster and gather state go back to zero.
	// The format and alpha writes carry random junk above their register width.
	task automatic set_image(input logic [FMT_W-1:0] fmt, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic [7:0] a);
		logic [9:0] junk;
		junk = 10'($urandom);
		wr_en    <= 1'b1;
		wr_index <= REG_FORMAT;
		wr_data  <= {junk, fmt};
		@(posedge clk);
		wr_index <= REG_WIDTH;
		wr_data  <= w;
		@(posedge clk);
		wr_index <= REG_HEIGHT;
		wr_data  <= h;
		@(posedge clk);
		wr_index <= REG_ALPHA;
		wr_data  <= {junk[4:0], a};
		@(posedge clk);
		wr_en <= 1'b0;
		fmt_reg      = fmt;
		width_reg    = w;
		height_reg   = h;
		alpha_reg    = a;
		col_pos      = '0;
		row_pos      = '0;
		gather_phase = '0;
	endtask

	function automatic logic [7:0] random_byte();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// One random image setting followed by a run of random bytes.
	task automatic random_phase(input int count);
		logic [FMT_W-1:0] fmt;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		if ($urandom_range(19) < 18)
			fmt = FMT_W'($urandom_range(4));
		else
			fmt = FMT_W'($urandom_range(7, 5));
		case ($urandom_range(15))
			0:       w = '0;
			1:       w = DIM_W'(MAX_DIM_DEF);
			2:       w = DIM_W'($urandom_range(8191, MAX_DIM_DEF + 1));
			3:       w = DIM_W'($urandom_range(300, 13));
			default: w = DIM_W'($urandom_range(12, 1));
		endcase
		case ($urandom_range(15))
			0:       h = '0;
			1:       h = DIM_W'($urandom_range(8191, MAX_DIM_DEF));
			default: h = DIM_W'($urandom_range(4, 1));
		endcase
		set_image(fmt, w, h, 8'($urandom));
		for (int i = 0; i < count; i++)
			offer(random_byte());
		wait_idle(8);
	endtask

	// Safety net against a hung handshake.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int random_items;
		int n;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		raw_ch.valid    = 1'b0;
		raw_ch.raw_byte = 8'd0;
		pix_ch.ready    = 1'b0;
		// Register values after reset.
		fmt_reg      = FMT_RGBA32;
		width_reg    = 13'd1;
		height_reg   = 13'd1;
		alpha_reg    = 8'hff;
		col_pos      = '0;
		row_pos      = '0;
		gather_phase = '0;
		gathered     = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First the reset setting, 32 bpp on a one-pixel image.
		offer(8'h00);
		offer(8'hff);
		offer(8'h00);
		offer(8'hff);
		wait_idle(8);

		// 24 bpp with a transparent alpha, two pixels in one row.
		set_image(FMT_RGB24, 13'd2, 13'd1, 8'h00);
		offer(8'hff);
		offer(8'h00);
		offer(8'hff);
		offer(8'h12);
		offer(8'h34);
		offer(8'h56);
		wait_idle(8);

		// 8 bpp with a zero width and a height beyond the maximum, both clamped.
		set_image(FMT_IDX8, 13'd0, 13'd8191, 8'h80);
		offer(8'h00);
		offer(8'hff);
		wait_idle(8);

		// 4 bpp with an odd width: bytes straddle rows and the image wraps.
		set_image(FMT_IDX4, 13'd3, 13'd1, 8'h7f);
		offer(8'ha5);
		offer(8'h5a);
		offer(8'h0f);
		wait_idle(8);

		// 1 bpp with a width that is not a multiple of eight.
		set_image(FMT_IDX1, 13'd5, 13'd2, 8'h01);
		offer(8'h80);
		offer(8'h01);
		wait_idle(8);

		// Undefined formats produce nothing.
		set_image(3'd5, 13'd4, 13'd4, 8'hfe);
		offer(8'h3c);
		wait_idle(8);
		set_image(3'd7, 13'd4, 13'd4, 8'hfe);
		offer(8'hc3);
		wait_idle(8);

		// A partial 32 bpp pixel on the largest image, abandoned by a register write;
		// the following pixel must start gathering from scratch.
		set_image(FMT_RGBA32, 13'd4096, 13'd4096, 8'hff);
		offer(8'h11);
		offer(8'h22);
		wait_idle(8);
		set_image(FMT_RGBA32, 13'd8191, 13'd0, 8'hff);
		offer(8'haa);
		offer(8'hbb);
		offer(8'hcc);
		offer(8'hdd);
		wait_idle(8);

		// Pressure: the receiver holds off for a long stretch while 8 bpp bytes keep
		// coming, so the block fills and stalls its input. Then the sender pauses
		// until every pixel has drained before it resumes.
		set_image(FMT_IDX8, 13'd7, 13'd3, 8'h40);
		hold_request <= 1'b1;
		for (int i = 0; i < 30; i++)
			offer(random_byte());
		wait_idle(0);
		for (int i = 0; i < 10; i++)
			offer(random_byte());
		wait_idle(8);
		random_items = 40;

		// Random part, in three idling regimes.
		while (random_items < 420) begin
			if (random_items < 140) begin
				send_idle_pct = 20;
				recv_idle_pct = 60;
			end else if (random_items < 280) begin
				send_idle_pct = 60;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			n = $urandom_range(40, 8);
			if (n > 420 - random_items)
				n = 420 - random_items;
			random_phase(n);
			random_items += n;
		end

		wait_idle(12);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- raw_pixel_unpacker_core.f -----
hw/rtl/rpu_pkg.sv
hw/rtl/rpu_byte_if.sv
hw/rtl/rpu_pixel_if.sv
hw/rtl/rpu_cfg.sv
hw/rtl/rpu_gather.sv
hw/rtl/rpu_emit.sv
hw/rtl/raw_pixel_unpacker_core.sv
verif/tb_top.sv
